/* rtl/alignment_column_features_defines.svh */
`ifndef ALIGNMENT_COLUMN_FEATURES_DEFINES_SVH
`define ALIGNMENT_COLUMN_FEATURES_DEFINES_SVH

// Same-cycle implication, clocked on the block clock, off during reset.
`define ACF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acf check failed");

// Next-cycle implication.
`define ACF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acf check failed");

`endif

/* rtl/acf_pkg.sv */
package acf_pkg;

   localparam int RES_W        = 8;
   localparam int CNT_W        = 11;
   localparam int COL_W        = 16;
   localparam int FRAC_W       = 17;
   localparam int EDGE_W       = 15;
   localparam int ENT_W        = 18;
   localparam int LETTER_SLOTS = 26;
   localparam int SLOT_W       = 5;
   localparam int HIST_W       = CNT_W + 16;
   localparam int HIST_DEPTH   = 5;
   localparam int DIV_W        = 41;
   localparam int DEN_W        = 12;
   localparam int DCNT_W       = 6;
   localparam int X_W          = 29;
   localparam int X2_W         = 28;
   localparam int SUM_W        = 31;
   localparam int LNQ_W        = 35;
   localparam int LN_W         = 21;
   localparam int S_W          = 32;
   localparam int SERIES_TERMS = 12;
   localparam int TERM_W       = 4;
   localparam int LOG_W        = 4;
   localparam int WSUM_W       = 30;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [29:0]      LN2_Q30     = 30'd744261118;
   localparam logic [LNQ_W-1:0] LN_ROUND    = 35'd8192;
   localparam logic [RES_W-1:0] CHAR_GAP    = 8'h2D;
   localparam logic [RES_W-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [RES_W-1:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [RES_W-1:0] CHAR_LO_A   = 8'h61;
   localparam logic [RES_W-1:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [RES_W-1:0] CASE_OFFSET = 8'h20;
   localparam logic [ENT_W-1:0] ENT_MAX     = '1;

   typedef enum logic {
      REG_NUM_SEQUENCES    = 1'b0,
      REG_ALIGNMENT_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      LN_RET_SCAN = 1'b0,
      LN_RET_ENT  = 1'b1
   } ln_ret_type;

endpackage

/* rtl/acf_req_if.sv */
interface acf_req_if import acf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] residue;

   modport source (output valid, output residue, input ready);
   modport sink (input valid, input residue, output ready);
endinterface

/* rtl/acf_rsp_if.sv */
interface acf_rsp_if import acf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  column;
   logic [FRAC_W-1:0] gap_fraction;
   logic [FRAC_W-1:0] identity_fraction;
   logic [EDGE_W-1:0] edge_distance;
   logic [ENT_W-1:0]  entropy;
   logic [FRAC_W-1:0] gap_window_one;
   logic [FRAC_W-1:0] gap_window_two;
   logic              last_column;
   logic              last_of_run;

   modport source (output valid, output column, output gap_fraction,
                   output identity_fraction, output edge_distance, output entropy,
                   output gap_window_one, output gap_window_two, output last_column,
                   output last_of_run, input ready);
   modport sink (input valid, input column, input gap_fraction, input identity_fraction,
                 input edge_distance, input entropy, input gap_window_one,
                 input gap_window_two, input last_column, input last_of_run,
                 output ready);
endinterface

/* rtl/alignment_column_features.sv */
// A residue that does not end a column only updates the counters, and the block stays ready for the next one.
// A column end runs a shift-subtract divider and one registered multiplier
// under a sequencer, plus one ln evaluation for each letter count above one and one
// for the column letter total when that total is nonzero.
// Each result waits for rsp ready; 0 to 3 results per column end.
// Synchronous active-high reset clears all counters and history and sets both configuration registers to 1.
`include "alignment_column_features_defines.svh"

module alignment_column_features import acf_pkg::*; #(
   parameter int MAX_SEQUENCES = 1024,
   parameter int MAX_COLUMNS   = 65535
) (
   input  logic                  clock,
   input  logic                  reset,
   acf_req_if.sink               req_chan,
   acf_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SEQ_CAP = (MAX_SEQUENCES > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_SEQUENCES;
   localparam int COL_CAP = (MAX_COLUMNS > (2**COL_W - 1)) ? (2**COL_W - 1) : MAX_COLUMNS;
   localparam logic [CNT_W-1:0] SEQ_CAP_V = CNT_W'(SEQ_CAP);
   localparam logic [COL_W-1:0] COL_CAP_V = COL_W'(COL_CAP);

   typedef enum logic [25:0] {
      ST_IDLE     = 26'h0000001,
      ST_GAP      = 26'h0000002,
      ST_GAP_WAIT = 26'h0000004,
      ST_SCAN     = 26'h0000008,
      ST_SCAN_MUL = 26'h0000010,
      ST_SCAN_ACC = 26'h0000020,
      ST_ID       = 26'h0000040,
      ST_ID_WAIT  = 26'h0000080,
      ST_LN_X     = 26'h0000100,
      ST_LN_XW    = 26'h0000200,
      ST_LN_SQ    = 26'h0000400,
      ST_LN_X2    = 26'h0000800,
      ST_LN_PW    = 26'h0001000,
      ST_LN_PW2   = 26'h0002000,
      ST_LN_TW    = 26'h0004000,
      ST_LN_K     = 26'h0008000,
      ST_LN_END   = 26'h0010000,
      ST_ENT_DIV  = 26'h0020000,
      ST_ENT_WAIT = 26'h0040000,
      ST_EMIT     = 26'h0080000,
      ST_W1       = 26'h0100000,
      ST_W1W      = 26'h0200000,
      ST_W2       = 26'h0400000,
      ST_W2W      = 26'h0800000,
      ST_OUT      = 26'h1000000,
      ST_FINISH   = 26'h2000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  ns_reg_ff, ns_reg_in;
   logic [COL_W-1:0]  len_reg_ff, len_reg_in;
   logic [CNT_W-1:0]  counts_ff [LETTER_SLOTS];
   logic [CNT_W-1:0]  counts_in [LETTER_SLOTS];
   logic [CNT_W-1:0]  gap_ff, gap_in, letter_ff, letter_in, row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [HIST_W-1:0] hist_ff [HIST_DEPTH];
   logic [HIST_W-1:0] hist_in [HIST_DEPTH];
   logic [FRAC_W-1:0] pend_id_ff [2];
   logic [FRAC_W-1:0] pend_id_in [2];
   logic [ENT_W-1:0]  pend_en_ff [2];
   logic [ENT_W-1:0]  pend_en_in [2];
   logic [FRAC_W-1:0] id_ff, id_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [ENT_W-1:0]  en_ff, en_in;
   logic [CNT_W-1:0]  maxc_ff, maxc_in, ln_arg_ff, ln_arg_in;
   logic [S_W-1:0]    s_ff, s_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   ln_ret_type        ln_ret_ff, ln_ret_in;
   logic [LOG_W-1:0]  k_ff, k_in;
   logic [X_W-1:0]    x_ff, x_in, pw_ff, pw_in;
   logic [X2_W-1:0]   x2_ff, x2_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic [LN_W-1:0]   ln_ff, ln_in;
   logic [1:0]        m_ff, m_in;
   logic              final_ff, final_in;
   logic [63:0]       prod_ff, prod_in;
   logic [31:0]       mul_a, mul_b;

   logic [DIV_W-1:0]  div_quo_ff, div_quo_in, div_num;
   logic [DEN_W-1:0]  div_rem_ff, div_rem_in, div_den_ff, div_den_in, div_den;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              div_start, div_done;
   logic [DEN_W:0]    div_rem_sh, div_rem_sub;
   logic              div_ge;

   logic [CNT_W-1:0]  ns_eff;
   logic [COL_W-1:0]  len_eff, len_m1;
   logic              req_acc, rsp_acc;
   logic [RES_W-1:0]  res_up;
   logic              res_gap, res_letter;
   logic [SLOT_W-1:0] res_slot;
   logic [CNT_W:0]    row_next;
   logic [CNT_W-1:0]  scan_cnt;
   logic [LOG_W-1:0]  ln_k;
   logic [DEN_W-1:0]  ln_p, ln_den;
   logic [CNT_W-1:0]  ln_diff;
   logic [LNQ_W-1:0]  ln_total;
   logic [DIV_W-1:0]  ln_ext, ent_h;
   logic [COL_W-1:0]  win_k, edge_dist;
   logic [WSUM_W-1:0] win_s1, win_s2;
   logic [2:0]        win_n1, win_n2, win_idx;
   logic              out_last;

   // configuration
   assign pready = 1'b1;
   assign ns_eff = (ns_reg_ff == '0) ? CNT_W'(1) :
                   ((ns_reg_ff > SEQ_CAP_V) ? SEQ_CAP_V : ns_reg_ff);
   assign len_eff = (len_reg_ff == '0) ? COL_W'(1) :
                    ((len_reg_ff > COL_CAP_V) ? COL_CAP_V : len_reg_ff);
   assign len_m1 = len_eff - COL_W'(1);

   always_comb begin
      unique case (csr_index_type'(paddr[2]))
         REG_NUM_SEQUENCES:    prdata = CSR_DATA_W'(ns_reg_ff);
         REG_ALIGNMENT_LENGTH: prdata = CSR_DATA_W'(len_reg_ff);
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      ns_reg_in  = ns_reg_ff;
      len_reg_in = len_reg_ff;
      if (psel && penable && pwrite) begin
         unique case (csr_index_type'(paddr[2]))
            REG_NUM_SEQUENCES:    ns_reg_in = pwdata[CNT_W-1:0];
            REG_ALIGNMENT_LENGTH: len_reg_in = pwdata[COL_W-1:0];
            default:              ns_reg_in = ns_reg_ff;
         endcase
      end
   end

   // residue decode
   assign req_acc    = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_acc    = rsp_chan.valid && rsp_chan.ready;
   assign res_gap    = (req_chan.residue == CHAR_GAP);
   assign res_up     = ((req_chan.residue >= CHAR_LO_A) && (req_chan.residue <= CHAR_LO_Z)) ?
                       (req_chan.residue - CASE_OFFSET) : req_chan.residue;
   assign res_letter = !res_gap && (res_up >= CHAR_UP_A) && (res_up <= CHAR_UP_Z);
   assign res_slot   = SLOT_W'(res_up - CHAR_UP_A);
   assign row_next   = {1'b0, row_ff} + (CNT_W+1)'(1);
   assign scan_cnt   = counts_ff[scan_idx_ff];

   // ln argument split into 2^k and the remainder
   always_comb begin
      ln_k = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (ln_arg_ff[i]) ln_k = LOG_W'(i);
      end
   end
   assign ln_p     = DEN_W'(1) << ln_k;
   assign ln_diff  = ln_arg_ff - ln_p[CNT_W-1:0];
   assign ln_den   = {1'b0, ln_arg_ff} + ln_p;
   assign ln_total = prod_ff[LNQ_W-1:0] + LNQ_W'({sum_ff, 1'b0}) + LN_ROUND;
   assign ln_ext   = DIV_W'(ln_ff);
   assign ent_h    = ln_ext - div_quo_ff;

   // window of gap fractions around the column being emitted
   assign win_k = col_ff - COL_W'(m_ff);
   always_comb begin
      win_s1  = '0;
      win_s2  = '0;
      win_n1  = '0;
      win_n2  = '0;
      win_idx = '0;
      for (int e = 0; e < HIST_DEPTH; e++) begin
         if ((int'(m_ff) >= e - 2) && ((e >= 2) || (int'(win_k) >= 2 - e))) begin
            win_idx = 3'(int'(m_ff) + 2 - e);
            win_s2  = win_s2 + WSUM_W'(hist_ff[win_idx]);
            win_n2  = win_n2 + 3'd1;
            if ((e >= 1) && (e <= 3)) begin
               win_s1 = win_s1 + WSUM_W'(hist_ff[win_idx]);
               win_n1 = win_n1 + 3'd1;
            end
         end
      end
   end

   assign edge_dist = (win_k >= len_m1) ? '0 :
                      ((win_k < (len_m1 - win_k)) ? win_k : (len_m1 - win_k));
   assign out_last  = !final_ff || (m_ff == 2'd0);

   assign req_chan.ready             = (state_ff == ST_IDLE);
   assign rsp_chan.valid             = (state_ff == ST_OUT);
   assign rsp_chan.column            = win_k;
   assign rsp_chan.gap_fraction      = hist_ff[{1'b0, m_ff}][FRAC_W-1:0];
   assign rsp_chan.identity_fraction = (m_ff == 2'd0) ? id_ff : pend_id_ff[m_ff[1]];
   assign rsp_chan.entropy           = (m_ff == 2'd0) ? en_ff : pend_en_ff[m_ff[1]];
   assign rsp_chan.edge_distance     = edge_dist[EDGE_W-1:0];
   assign rsp_chan.gap_window_one    = w1_ff;
   assign rsp_chan.gap_window_two    = w2_ff;
   assign rsp_chan.last_column       = final_ff && (m_ff == 2'd0);
   assign rsp_chan.last_of_run       = out_last;

   // shared divider, one quotient bit a cycle
   assign div_rem_sh  = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_ge      = div_rem_sh >= {1'b0, div_den_ff};
   assign div_rem_sub = div_rem_sh - {1'b0, div_den_ff};
   assign div_done    = (div_cnt_ff == '0);

   always_comb begin
      div_quo_in = div_quo_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_start) begin
         div_quo_in = div_num;
         div_rem_in = '0;
         div_den_in = div_den;
         div_cnt_in = DCNT_W'(DIV_W);
      end else if (!div_done) begin
         div_quo_in = {div_quo_ff[DIV_W-2:0], div_ge};
         div_rem_in = div_ge ? div_rem_sub[DEN_W-1:0] : div_rem_sh[DEN_W-1:0];
         div_cnt_in = div_cnt_ff - DCNT_W'(1);
      end
   end

   // shared multiplier, registered
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      counts_in   = counts_ff;
      gap_in      = gap_ff;
      letter_in   = letter_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      hist_in     = hist_ff;
      pend_id_in  = pend_id_ff;
      pend_en_in  = pend_en_ff;
      id_in       = id_ff;
      en_in       = en_ff;
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      maxc_in     = maxc_ff;
      s_in        = s_ff;
      scan_idx_in = scan_idx_ff;
      ln_arg_in   = ln_arg_ff;
      ln_ret_in   = ln_ret_ff;
      k_in        = k_ff;
      x_in        = x_ff;
      x2_in       = x2_ff;
      pw_in       = pw_ff;
      sum_in      = sum_ff;
      term_in     = term_ff;
      ln_in       = ln_ff;
      m_in        = m_ff;
      final_in    = final_ff;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = DEN_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (res_gap) gap_in = gap_ff + CNT_W'(1);
               if (res_letter) letter_in = letter_ff + CNT_W'(1);
               for (int i = 0; i < LETTER_SLOTS; i++) begin
                  if (res_letter && (res_slot == SLOT_W'(i))) begin
                     counts_in[i] = counts_ff[i] + CNT_W'(1);
                  end
               end
               if (row_next >= {1'b0, ns_eff}) begin
                  state_in = ST_GAP;
               end else begin
                  row_in = row_next[CNT_W-1:0];
               end
            end
         end
         ST_GAP: begin
            div_start = 1'b1;
            div_num   = DIV_W'({gap_ff, 16'b0});
            div_den   = DEN_W'(ns_eff);
            state_in  = ST_GAP_WAIT;
         end
         ST_GAP_WAIT: begin
            if (div_done) begin
               for (int i = HIST_DEPTH - 1; i > 0; i--) hist_in[i] = hist_ff[i-1];
               hist_in[0]  = div_quo_ff[HIST_W-1:0];
               maxc_in     = '0;
               s_in        = '0;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_cnt > maxc_ff) maxc_in = scan_cnt;
            if (scan_cnt > CNT_W'(1)) begin
               ln_arg_in = scan_cnt;
               ln_ret_in = LN_RET_SCAN;
               state_in  = ST_LN_X;
            end else if (scan_idx_ff == SLOT_W'(LETTER_SLOTS - 1)) begin
               state_in = ST_ID;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end
         ST_SCAN_MUL: begin
            mul_a    = 32'(ln_arg_ff);
            mul_b    = 32'(ln_ff);
            state_in = ST_SCAN_ACC;
         end
         ST_SCAN_ACC: begin
            s_in = s_ff + prod_ff[S_W-1:0];
            if (scan_idx_ff == SLOT_W'(LETTER_SLOTS - 1)) begin
               state_in = ST_ID;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_ID: begin
            div_start = 1'b1;
            div_num   = DIV_W'({maxc_ff, 16'b0});
            div_den   = DEN_W'(ns_eff);
            state_in  = ST_ID_WAIT;
         end
         ST_ID_WAIT: begin
            if (div_done) begin
               id_in = div_quo_ff[FRAC_W-1:0];
               if (letter_ff != '0) begin
                  ln_arg_in = letter_ff;
                  ln_ret_in = LN_RET_ENT;
                  state_in  = ST_LN_X;
               end else begin
                  en_in    = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_LN_X: begin
            k_in      = ln_k;
            div_start = 1'b1;
            div_num   = {ln_diff, 30'b0};
            div_den   = ln_den;
            state_in  = ST_LN_XW;
         end
         ST_LN_XW: begin
            if (div_done) begin
               x_in     = div_quo_ff[X_W-1:0];
               pw_in    = div_quo_ff[X_W-1:0];
               sum_in   = SUM_W'(div_quo_ff[X_W-1:0]);
               term_in  = TERM_W'(1);
               state_in = ST_LN_SQ;
            end
         end
         ST_LN_SQ: begin
            mul_a    = 32'(x_ff);
            mul_b    = 32'(x_ff);
            state_in = ST_LN_X2;
         end
         ST_LN_X2: begin
            x2_in    = prod_ff[X2_W+29:30];
            state_in = ST_LN_PW;
         end
         ST_LN_PW: begin
            mul_a    = 32'(pw_ff);
            mul_b    = 32'(x2_ff);
            state_in = ST_LN_PW2;
         end
         ST_LN_PW2: begin
            pw_in     = prod_ff[X_W+29:30];
            div_start = 1'b1;
            div_num   = DIV_W'(prod_ff[X_W+29:30]);
            div_den   = DEN_W'({term_ff, 1'b1});
            state_in  = ST_LN_TW;
         end
         ST_LN_TW: begin
            if (div_done) begin
               sum_in = sum_ff + SUM_W'(div_quo_ff[X_W-1:0]);
               if (term_ff == TERM_W'(SERIES_TERMS)) begin
                  state_in = ST_LN_K;
               end else begin
                  term_in  = term_ff + TERM_W'(1);
                  state_in = ST_LN_PW;
               end
            end
         end
         ST_LN_K: begin
            mul_a    = 32'(k_ff);
            mul_b    = 32'(LN2_Q30);
            state_in = ST_LN_END;
         end
         ST_LN_END: begin
            ln_in    = ln_total[LNQ_W-1:14];
            state_in = (ln_ret_ff == LN_RET_SCAN) ? ST_SCAN_MUL : ST_ENT_DIV;
         end
         ST_ENT_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(s_ff);
            div_den   = DEN_W'(letter_ff);
            state_in  = ST_ENT_WAIT;
         end
         ST_ENT_WAIT: begin
            if (div_done) begin
               if (ln_ext > div_quo_ff) begin
                  en_in = (ent_h > DIV_W'(ENT_MAX)) ? ENT_MAX : ent_h[ENT_W-1:0];
               end else begin
                  en_in = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            final_in = (col_ff >= len_m1);
            if (col_ff >= len_m1) begin
               m_in     = (col_ff >= COL_W'(2)) ? 2'd2 :
                          ((col_ff >= COL_W'(1)) ? 2'd1 : 2'd0);
               state_in = ST_W1;
            end else if (col_ff >= COL_W'(2)) begin
               m_in     = 2'd2;
               state_in = ST_W1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_W1: begin
            div_start = 1'b1;
            div_num   = DIV_W'(win_s1);
            div_den   = DEN_W'(win_n1);
            state_in  = ST_W1W;
         end
         ST_W1W: begin
            if (div_done) begin
               w1_in    = div_quo_ff[FRAC_W-1:0];
               state_in = ST_W2;
            end
         end
         ST_W2: begin
            div_start = 1'b1;
            div_num   = DIV_W'(win_s2);
            div_den   = DEN_W'(win_n2);
            state_in  = ST_W2W;
         end
         ST_W2W: begin
            if (div_done) begin
               w2_in    = div_quo_ff[FRAC_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               if (out_last) begin
                  state_in = ST_FINISH;
               end else begin
                  m_in     = m_ff - 2'd1;
                  state_in = ST_W1;
               end
            end
         end
         ST_FINISH: begin
            for (int i = 0; i < LETTER_SLOTS; i++) counts_in[i] = '0;
            gap_in    = '0;
            letter_in = '0;
            row_in    = '0;
            if (final_ff) begin
               // alignment done: next residue opens column 0
               for (int i = 0; i < HIST_DEPTH; i++) hist_in[i] = '0;
               pend_id_in[0] = '0;
               pend_id_in[1] = '0;
               pend_en_in[0] = '0;
               pend_en_in[1] = '0;
               col_in        = '0;
            end else begin
               pend_id_in[1] = pend_id_ff[0];
               pend_en_in[1] = pend_en_ff[0];
               pend_id_in[0] = id_ff;
               pend_en_in[0] = en_ff;
               col_in        = col_ff + COL_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ns_reg_ff  <= CNT_W'(1);
         len_reg_ff <= COL_W'(1);
         for (int i = 0; i < LETTER_SLOTS; i++) counts_ff[i] <= '0;
         gap_ff     <= '0;
         letter_ff  <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) hist_ff[i] <= '0;
         pend_id_ff[0] <= '0;
         pend_id_ff[1] <= '0;
         pend_en_ff[0] <= '0;
         pend_en_ff[1] <= '0;
         div_cnt_ff <= '0;
         m_ff       <= '0;
         final_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ns_reg_ff  <= ns_reg_in;
         len_reg_ff <= len_reg_in;
         counts_ff  <= counts_in;
         gap_ff     <= gap_in;
         letter_ff  <= letter_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         hist_ff    <= hist_in;
         pend_id_ff <= pend_id_in;
         pend_en_ff <= pend_en_in;
         div_cnt_ff <= div_cnt_in;
         m_ff       <= m_in;
         final_ff   <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      en_ff       <= en_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      maxc_ff     <= maxc_in;
      s_ff        <= s_in;
      scan_idx_ff <= scan_idx_in;
      ln_arg_ff   <= ln_arg_in;
      ln_ret_ff   <= ln_ret_in;
      k_ff        <= k_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      pw_ff       <= pw_in;
      sum_ff      <= sum_in;
      term_ff     <= term_in;
      ln_ff       <= ln_in;
      prod_ff     <= prod_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
   end

   `ACF_ASSERT_IMPLY(a_no_intake_while_result, rsp_chan.valid, !req_chan.ready)
   `ACF_ASSERT_IMPLY(a_div_launch_when_free, div_start, div_cnt_ff == '0)
   `ACF_ASSERT_NEXT(a_run_end_drops_valid, rsp_acc && rsp_chan.last_of_run, !rsp_chan.valid)
   `ACF_ASSERT_IMPLY(a_scan_in_range, state_ff == ST_SCAN,
                     scan_idx_ff < SLOT_W'(LETTER_SLOTS))

endmodule
